// ===== hdl/mt64_pkg.sv =====
`default_nettype none

package mt64_pkg;

	localparam int STATE_WORDS   = 312;
	localparam int MIDDLE_OFFSET = 156;
	localparam int IDX_W         = 9;
	localparam int WORD_W        = 64;

	localparam logic KIND_SEED = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	localparam logic [WORD_W-1:0] SEED_MULT   = 64'd6364136223846793005;
	localparam logic [WORD_W-1:0] UPPER_MASK  = 64'hffffffff80000000;
	localparam logic [WORD_W-1:0] LOWER_MASK  = 64'h000000007fffffff;
	localparam logic [WORD_W-1:0] MATRIX_A    = 64'hb5026f5aa96619e9;
	localparam logic [WORD_W-1:0] TEMPER_MASK_U = 64'h5555555555555555;
	localparam logic [WORD_W-1:0] TEMPER_MASK_B = 64'h71d67fffeda60000;
	localparam logic [WORD_W-1:0] TEMPER_MASK_C = 64'hfff7eee000000000;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic  en;
		idx_t  addr;
		word_t data;
	} mem_wr_t;

	function automatic idx_t idx_add(idx_t i, idx_t off);
		logic [IDX_W:0] sum;
		sum = {1'b0, i} + {1'b0, off};
		if (sum >= (IDX_W+1)'(STATE_WORDS))
			sum = sum - (IDX_W+1)'(STATE_WORDS);
		return sum[IDX_W-1:0];
	endfunction

	function automatic word_t twist(word_t cur, word_t nxt, word_t mid);
		word_t z;
		z = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
		return mid ^ (z >> 1) ^ (z[0] ? MATRIX_A : '0);
	endfunction

	function automatic word_t temper(word_t y_in);
		word_t y;
		y = y_in;
		y = y ^ ((y >> 29) & TEMPER_MASK_U);
		y = y ^ ((y << 17) & TEMPER_MASK_B);
		y = y ^ ((y << 37) & TEMPER_MASK_C);
		y = y ^ (y >> 43);
		return y;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/mt19937_64_generator_core.sv =====
`default_nettype none

// MT19937-64 generator core.
// Command port: an item is taken on a clock edge with start high and busy low.
// kind = 0 seeds the generator from the signed 32-bit seed_value; kind = 1
// draws one tempered 64-bit word. A draw result shows on random_value with done
// high for exactly one cycle; the receiver cannot stall it.
// Draw: busy for one cycle after the transfer, done in the cycle after that,
// so a new draw can start in the cycle done is high. The steps follow the
// 312 x 64 state memory: its two registered read ports give the next word
// and the middle word, then the twist state twists, writes back and tempers.
// Seed: busy while words 1 to 311 are filled, no result. Each word needs the
// previous one, split into a registered 32 x 32 partial-product step and an
// add step.
// Reset clears the index and the control state; the state memory is not
// cleared, so draws are meaningful only after a seed.

module mt19937_64_generator_core
	import mt64_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic        kind,
	input  wire logic signed [31:0] seed_value,
	output      logic        done,
	output      logic [63:0] random_value
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_TWIST
	} state_t;

	state_t  state_q;
	idx_t    idx_q;
	idx_t    fill_q;
	word_t   prev_q;
	word_t   cur_q;
	word_t   random_value_q;
	logic    done_q;

	logic    accept;
	word_t   seed_ext;
	word_t   seed_word;
	word_t   rd_next;
	word_t   rd_mid;
	word_t   twisted;
	idx_t    rd_addr_a;
	idx_t    rd_addr_b;
	mem_wr_t wr;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign seed_ext = {{32{seed_value[31]}}, seed_value};

	assign rd_addr_a = idx_add(idx_q, IDX_W'(1));
	assign rd_addr_b = idx_add(idx_q, IDX_W'(MIDDLE_OFFSET));
	assign twisted   = twist(cur_q, rd_next, rd_mid);

	mt64_ram u_ram (
		.clk       (clk),
		.wr        (wr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_next),
		.rd_data_b (rd_mid)
	);

	mt64_seed_step u_seed (
		.clk  (clk),
		.prev (prev_q),
		.fill (fill_q),
		.word (seed_word)
	);

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = idx_q;
		wr.data = twisted;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (kind == KIND_SEED)) begin
					wr.en   = 1'b1;
					wr.addr = '0;
					wr.data = seed_ext;
				end
			end
			S_MUL: begin
				wr.en = 1'b0;
			end
			S_ADD: begin
				wr.en   = 1'b1;
				wr.addr = fill_q;
				wr.data = seed_word;
			end
			S_TWIST: begin
				wr.en = 1'b1;
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			idx_q          <= '0;
			fill_q         <= '0;
			prev_q         <= '0;
			cur_q          <= '0;
			random_value_q <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_DRAW) begin
							state_q <= S_TWIST;
						end else begin
							prev_q  <= seed_ext;
							cur_q   <= seed_ext;
							idx_q   <= '0;
							fill_q  <= IDX_W'(1);
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					prev_q <= seed_word;
					if (fill_q == IDX_W'(STATE_WORDS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						fill_q  <= fill_q + IDX_W'(1);
						state_q <= S_MUL;
					end
				end
				S_TWIST: begin
					random_value_q <= temper(twisted);
					done_q         <= 1'b1;
					cur_q          <= rd_next;
					idx_q          <= rd_addr_a;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign random_value = random_value_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind == KIND_DRAW)) |-> ##2 done)
		else $error("draw did not finish in two cycles");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind == KIND_SEED)) |=> !done)
		else $error("seed produced a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_TWIST))
		else $error("result without a twist step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q < IDX_W'(STATE_WORDS)) && (fill_q < IDX_W'(STATE_WORDS)))
		else $error("index out of range");

endmodule

`default_nettype wire

// ===== hdl/mt64_ram.sv =====
`default_nettype none

module mt64_ram
	import mt64_pkg::*;
(
	input  wire logic    clk,
	input  wire mem_wr_t wr,
	input  wire idx_t    rd_addr_a,
	input  wire idx_t    rd_addr_b,
	output      word_t   rd_data_a,
	output      word_t   rd_data_b
);

	word_t mem [STATE_WORDS];
	word_t rd_a_q;
	word_t rd_b_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

`default_nettype wire

// ===== hdl/mt64_seed_step.sv =====
`default_nettype none

module mt64_seed_step
	import mt64_pkg::*;
(
	input  wire logic  clk,
	input  wire word_t prev,
	input  wire idx_t  fill,
	output      word_t word
);

	word_t        x;
	word_t        p0;
	logic [31:0]  p1;
	logic [31:0]  p2;
	word_t        p0_s1;
	logic [31:0]  p1_s1;
	logic [31:0]  p2_s1;
	logic [31:0]  cross_sum;

	assign x  = prev ^ (prev >> 62);
	assign p0 = x[31:0] * SEED_MULT[31:0];
	assign p1 = x[63:32] * SEED_MULT[31:0];
	assign p2 = x[31:0] * SEED_MULT[63:32];

	always_ff @(posedge clk) begin
		p0_s1 <= p0;
		p1_s1 <= p1;
		p2_s1 <= p2;
	end

	assign cross_sum = p1_s1 + p2_s1;
	assign word      = p0_s1 + {cross_sum, 32'd0} + {{(WORD_W-IDX_W){1'b0}}, fill};

endmodule

`default_nettype wire
